@@ rtl/ercpu_pkg.sv @@
// Shared types, opcodes and constants for the eight-register CPU execute core.
package ercpu_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int PLEN_W    = 9;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 9'd256;

    // opcodes
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_LDR  = 5'd1;
    localparam logic [4:0] OP_STR  = 5'd2;
    localparam logic [4:0] OP_ADD  = 5'd3;
    localparam logic [4:0] OP_SUB  = 5'd4;
    localparam logic [4:0] OP_MOV  = 5'd5;
    localparam logic [4:0] OP_CMP  = 5'd6;
    localparam logic [4:0] OP_B    = 5'd7;
    localparam logic [4:0] OP_BEQ  = 5'd8;
    localparam logic [4:0] OP_BNE  = 5'd9;
    localparam logic [4:0] OP_BLT  = 5'd10;
    localparam logic [4:0] OP_BGT  = 5'd11;
    localparam logic [4:0] OP_AND  = 5'd12;
    localparam logic [4:0] OP_ORR  = 5'd13;
    localparam logic [4:0] OP_EOR  = 5'd14;
    localparam logic [4:0] OP_MVN  = 5'd15;
    localparam logic [4:0] OP_LSL  = 5'd16;
    localparam logic [4:0] OP_LSR  = 5'd17;
    localparam logic [4:0] OP_HALT = 5'd18;

    localparam logic CMD_PRELOAD = 1'b1;

    // stop causes
    localparam logic [1:0] CAUSE_RUN     = 2'd0;
    localparam logic [1:0] CAUSE_HALT    = 2'd1;
    localparam logic [1:0] CAUSE_END     = 2'd2;
    localparam logic [1:0] CAUSE_UNKNOWN = 2'd3;

    // compare codes
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;
    localparam logic [1:0] CMP_LT = 2'd3;

    typedef struct packed {
        logic       command;
        logic [4:0] opcode;
        logic [2:0] dest_reg;
        logic [2:0] src_reg;
        logic [2:0] second_reg;
        logic       use_immediate;
        logic [7:0] immediate;
        logic [7:0] address;
        logic [7:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       stopped;
        logic [1:0] stop_cause;
        logic [7:0] written_value;
        logic [1:0] compare_code;
        logic       branch_taken;
    } t_out_item;

    typedef enum logic [3:0] {
        K_PRELOAD,
        K_NOP,
        K_LDR,
        K_STR,
        K_ALU,
        K_MOV,
        K_CMP,
        K_BRANCH,
        K_HALT,
        K_UNKNOWN
    } t_kind;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_ORR,
        ALU_EOR,
        ALU_MVN,
        ALU_LSL,
        ALU_LSR
    } t_alu_op;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_EQ,
        COND_NE,
        COND_LT,
        COND_GT
    } t_cond;

    // classified instruction as it sits in the queue
    typedef struct packed {
        t_kind              kind;
        t_alu_op            alu_op;
        t_cond              cond;
        logic               use_imm;
        logic [REG_AW-1:0]  idx_a;
        logic [REG_AW-1:0]  idx_b;
        logic [REG_AW-1:0]  idx_d;
        logic [7:0]         imm;
        logic [MEM_AW-1:0]  addr;
        logic [7:0]         target;
        logic [7:0]         lval;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/ercpu_front.sv @@
// Front end: input handshake and instruction classification.
module ercpu_front import ercpu_pkg::*; (
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_entry   o_entry
);

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    always_comb begin
        o_entry         = '0;
        o_entry.kind    = K_UNKNOWN;
        o_entry.alu_op  = ALU_ADD;
        o_entry.cond    = COND_ALWAYS;
        o_entry.use_imm = i_in_data.use_immediate;
        o_entry.idx_a   = i_in_data.src_reg[REG_AW-1:0];
        o_entry.idx_d   = i_in_data.dest_reg[REG_AW-1:0];
        o_entry.imm     = i_in_data.immediate;
        o_entry.addr    = i_in_data.address[MEM_AW-1:0];
        o_entry.target  = i_in_data.address;
        o_entry.lval    = i_in_data.load_value;
        // port B carries the stored / first compared register for STR and CMP
        if (i_in_data.opcode == OP_STR || i_in_data.opcode == OP_CMP) begin
            o_entry.idx_b = i_in_data.dest_reg[REG_AW-1:0];
        end else begin
            o_entry.idx_b = i_in_data.second_reg[REG_AW-1:0];
        end

        case (i_in_data.opcode)
            OP_NOP:  o_entry.kind = K_NOP;
            OP_LDR:  o_entry.kind = K_LDR;
            OP_STR:  o_entry.kind = K_STR;
            OP_MOV:  o_entry.kind = K_MOV;
            OP_CMP:  o_entry.kind = K_CMP;
            OP_HALT: o_entry.kind = K_HALT;
            OP_ADD: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_ADD;
            end
            OP_SUB: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_SUB;
            end
            OP_AND: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_AND;
            end
            OP_ORR: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_ORR;
            end
            OP_EOR: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_EOR;
            end
            OP_MVN: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_MVN;
            end
            OP_LSL: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_LSL;
            end
            OP_LSR: begin
                o_entry.kind = K_ALU; o_entry.alu_op = ALU_LSR;
            end
            OP_B: begin
                o_entry.kind = K_BRANCH; o_entry.cond = COND_ALWAYS;
            end
            OP_BEQ: begin
                o_entry.kind = K_BRANCH; o_entry.cond = COND_EQ;
            end
            OP_BNE: begin
                o_entry.kind = K_BRANCH; o_entry.cond = COND_NE;
            end
            OP_BLT: begin
                o_entry.kind = K_BRANCH; o_entry.cond = COND_LT;
            end
            OP_BGT: begin
                o_entry.kind = K_BRANCH; o_entry.cond = COND_GT;
            end
            default: o_entry.kind = K_UNKNOWN;
        endcase

        // preload overrides whatever the opcode says
        if (i_in_data.command == CMD_PRELOAD) begin
            o_entry.kind = K_PRELOAD;
        end
    end

endmodule

@@ rtl/ercpu_queue.sv @@
// Small FIFO between the front end and the execute back end.
module ercpu_queue import ercpu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    t_entry          r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        if (p == Q_AW'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_head       = r_q[r_rp];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_entry;
        end
    end

endmodule

@@ rtl/ercpu_back.sv @@
// Back end: operand read, execute, architectural state and result register.
module ercpu_back import ercpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PLEN_W-1:0] i_cfg_wdata,
    input  t_q_stat           i_q_stat,
    input  t_entry            i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    output logic              o_halted
);

    // architectural state
    logic [PLEN_W-1:0]    r_plen;
    logic [7:0]           r_pc;
    logic [1:0]           r_cmp;
    logic                 r_halted;
    logic [1:0]           r_cause;
    logic [7:0]           r_rf [NUM_REGS];
    logic [7:0]           r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_vld;

    // execute stage
    logic       r_ex_vld;
    t_entry     r_ex;
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;
    logic [7:0] r_rd_m;

    // result register
    logic      r_out_vld;
    t_out_item r_out;

    logic              ex_fire;
    logic [7:0]        n_pc;
    logic [1:0]        n_cmp;
    logic              n_halted;
    logic [1:0]        n_cause;
    logic              rf_we;
    logic [7:0]        rf_wd;
    logic              mem_we;
    logic [7:0]        mem_wd;
    logic [7:0]        written;
    logic              taken;
    logic [7:0]        op_b;
    logic [7:0]        cmp_y;
    logic [7:0]        alu_res;
    logic              cond_ok;
    logic [PLEN_W-1:0] next_line;
    t_out_item         res;

    assign ex_fire     = r_ex_vld && (!r_out_vld || i_out_ready);
    assign o_pop       = !i_q_stat.empty && (!r_ex_vld || ex_fire);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_halted    = r_halted;

    assign op_b  = r_ex.use_imm ? r_ex.imm : r_rd_b;
    assign cmp_y = r_ex.use_imm ? r_ex.imm : r_rd_a;

    always_comb begin
        case (r_ex.alu_op)
            ALU_ADD: alu_res = r_rd_a + op_b;
            ALU_SUB: alu_res = r_rd_a - op_b;
            ALU_AND: alu_res = r_rd_a & op_b;
            ALU_ORR: alu_res = r_rd_a | op_b;
            ALU_EOR: alu_res = r_rd_a ^ op_b;
            ALU_MVN: alu_res = ~r_rd_a;
            ALU_LSL: alu_res = (|op_b[7:3]) ? 8'd0 : (r_rd_a << op_b[2:0]);
            ALU_LSR: alu_res = (|op_b[7:3]) ? 8'd0 : (r_rd_a >> op_b[2:0]);
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        case (r_ex.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_EQ:     cond_ok = (r_cmp == CMP_EQ);
            COND_NE:     cond_ok = (r_cmp == CMP_GT) || (r_cmp == CMP_LT);
            COND_LT:     cond_ok = (r_cmp == CMP_LT);
            COND_GT:     cond_ok = (r_cmp == CMP_GT);
            default:     cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_pc      = r_pc;
        n_cmp     = r_cmp;
        n_halted  = r_halted;
        n_cause   = r_cause;
        rf_we     = 1'b0;
        rf_wd     = alu_res;
        mem_we    = 1'b0;
        mem_wd    = r_rd_b;
        written   = '0;
        taken     = 1'b0;
        next_line = {1'b0, r_pc} + 1'b1;

        if (r_ex.kind == K_PRELOAD) begin
            mem_we  = 1'b1;
            mem_wd  = r_ex.lval;
            written = r_ex.lval;
        end else if (!r_halted) begin
            if ({1'b0, r_pc} >= r_plen) begin
                n_halted = 1'b1;
                n_cause  = CAUSE_END;
            end else if (r_ex.kind == K_HALT) begin
                n_halted = 1'b1;
                n_cause  = CAUSE_HALT;
            end else if (r_ex.kind == K_UNKNOWN) begin
                n_halted = 1'b1;
                n_cause  = CAUSE_UNKNOWN;
            end else begin
                case (r_ex.kind)
                    K_LDR: begin
                        rf_we = 1'b1; rf_wd = r_rd_m;
                    end
                    K_STR: mem_we = 1'b1;
                    K_ALU: rf_we = 1'b1;
                    K_MOV: begin
                        rf_we = 1'b1; rf_wd = cmp_y;
                    end
                    K_CMP: begin
                        if (r_rd_b == cmp_y) begin
                            n_cmp = CMP_EQ;
                        end else if (r_rd_b > cmp_y) begin
                            n_cmp = CMP_GT;
                        end else begin
                            n_cmp = CMP_LT;
                        end
                    end
                    K_BRANCH: taken = cond_ok;
                    default: ;
                endcase
                if (rf_we) begin
                    written = rf_wd;
                end else if (mem_we) begin
                    written = mem_wd;
                end
                if (taken) begin
                    next_line = {1'b0, r_ex.target};
                end
                // next line past the program end stops; pc keeps its value
                if (next_line >= r_plen) begin
                    n_halted = 1'b1;
                    n_cause  = CAUSE_END;
                end else begin
                    n_pc = next_line[7:0];
                end
            end
        end

        res.next_pc       = n_pc;
        res.stopped       = n_halted;
        res.stop_cause    = n_cause;
        res.written_value = written;
        res.compare_code  = n_cmp;
        res.branch_taken  = taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen    <= PLEN_RESET;
            r_pc      <= '0;
            r_cmp     <= '0;
            r_halted  <= 1'b0;
            r_cause   <= CAUSE_RUN;
            r_mem_vld <= '0;
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if (ex_fire) begin
                r_pc     <= n_pc;
                r_cmp    <= n_cmp;
                r_halted <= n_halted;
                r_cause  <= n_cause;
                if (rf_we) begin
                    r_rf[r_ex.idx_d] <= rf_wd;
                end
                if (mem_we) begin
                    r_mem_vld[r_ex.addr] <= 1'b1;
                end
            end
            if (o_pop) begin
                r_ex_vld <= 1'b1;
            end else if (ex_fire) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // operand reads at pop, write-first bypass from the retiring instruction
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ex <= i_head;
            if (ex_fire && rf_we && r_ex.idx_d == i_head.idx_a) begin
                r_rd_a <= rf_wd;
            end else begin
                r_rd_a <= r_rf[i_head.idx_a];
            end
            if (ex_fire && rf_we && r_ex.idx_d == i_head.idx_b) begin
                r_rd_b <= rf_wd;
            end else begin
                r_rd_b <= r_rf[i_head.idx_b];
            end
            if (ex_fire && mem_we && r_ex.addr == i_head.addr) begin
                r_rd_m <= mem_wd;
            end else if (r_mem_vld[i_head.addr]) begin
                r_rd_m <= r_mem[i_head.addr];
            end else begin
                r_rd_m <= '0;
            end
        end
        if (ex_fire) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_fire && mem_we) begin
            r_mem[r_ex.addr] <= mem_wd;
        end
    end

endmodule

@@ rtl/eight_register_cpu_execute_step.sv @@
// Top level of the eight-register CPU execute core: front end, queue, back end.
// One decoded instruction (or data preload) per input transfer, one result per
// transfer, in order. The core sustains one transfer per clock on both
// channels while the receiver keeps i_out_ready high; each item passes from
// the queue slot written at the transfer through the execute register to the
// result register. Operands of the register file and
// the 256-word data store are read as an instruction leaves the queue, with a
// bypass from the instruction retiring in the same cycle, so dependent
// instructions back to back run at full rate. The data store is cleared at
// reset through per-word valid bits, so no clearing pass is needed and items
// are taken right after reset. program_length is written through i_cfg_we /
// i_cfg_wdata and should only change while the core is idle.
module eight_register_cpu_execute_step_core import ercpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [PLEN_W-1:0] i_cfg_wdata
);

    logic    w_push;
    logic    w_pop;
    t_entry  w_entry;
    t_entry  w_head;
    t_q_stat w_q_stat;
    logic    w_halted;

    // classify incoming transfers
    ercpu_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    // decouples input acceptance from execute stalls
    ercpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // execute and hold machine state
    ercpu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (w_q_stat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_halted    (w_halted)
    );

    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("queue push while full");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("queue pop while empty");

    // only reset restarts a stopped machine
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(w_halted))
        else $error("halted flag cleared without reset");

endmodule

@@ dv/tb_eight_register_cpu_execute_step_core.sv @@
`timescale 1ns / 1ps
// Testbench for the eight-register CPU execute core: directed table, random programs, one stop.

module tb_eight_register_cpu_execute_step_core;
    import ercpu_pkg::*;

    localparam logic       CMD_EXECUTE  = 1'b0;
    localparam logic [1:0] CMP_NONE     = 2'd0;
    localparam int         IDLE_PCT     = 25;   // idle share on each side, percent
    localparam int         HOLD_CYCLES  = 80;   // one long receiver hold-off
    localparam int         HOLD_AFTER   = 200;  // transfers before the hold-off starts
    localparam int         DRAIN_CYCLES = 8;    // quiet time after the last result
    localparam int         STOPPED_ITEMS = 40;

    // The machine only leaves the stopped state through reset, and reset is
    // applied once, so a run can show just one way of stopping. The seed picks it.
    typedef enum int {
        FIN_HALT,
        FIN_UNKNOWN,
        FIN_LAST_LINE,
        FIN_BRANCH_OUT,
        FIN_FETCH_PAST
    } t_finish_kind;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    logic              cfg_we;
    logic [PLEN_W-1:0] cfg_wdata;

    // Shadow copy of the architectural state
    logic [7:0]        cpu_regs [NUM_REGS];
    logic [7:0]        dmem [MEM_DEPTH];
    logic [1:0]        cpu_cmp;
    logic [1:0]        cpu_cause;
    logic [7:0]        cpu_pc;
    logic              cpu_stopped;
    logic [PLEN_W-1:0] cpu_plen;

    t_out_item   pending_results [$];
    t_dir_row    dir_rows [$];
    int unsigned err_count;
    int unsigned sent_count;
    bit          steady;     // no idling on either side while set
    bit          hold_used;

    // Random phases: program length (0 = pick at random) and item count.
    // The last phase must allow at least two lines for the final stop.
    int plan_len   [6] = '{256, 1, 2, 16, 255, 0};
    int plan_items [6] = '{400, 60, 80, 250, 400, 400};

    eight_register_cpu_execute_step_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the core hangs
    initial begin
        #5_000_000;
        $display("tb_eight_register_cpu_execute_step_core failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic t_in_item mk_op(int op, int d, int s, int t, int ui, int imm,
                                       int addr);
        t_in_item it;
        it               = '0;
        it.command       = CMD_EXECUTE;
        it.opcode        = 5'(op);
        it.dest_reg      = 3'(d);
        it.src_reg       = 3'(s);
        it.second_reg    = 3'(t);
        it.use_immediate = 1'(ui);
        it.immediate     = 8'(imm);
        it.address       = 8'(addr);
        return it;
    endfunction

    function automatic t_in_item mk_load(logic [7:0] addr, logic [7:0] val);
        t_in_item it;
        it            = '0;
        it.command    = CMD_PRELOAD;
        it.address    = addr;
        it.load_value = val;
        return it;
    endfunction

    // Expected result of a running machine, for the hand-written table rows
    function automatic t_out_item running_at(logic [7:0] pc, logic [7:0] wv,
                                             logic [1:0] cc, logic br);
        return '{pc, 1'b0, CAUSE_RUN, wv, cc, br};
    endfunction

    task automatic add_row(input t_in_item it, input bit typed = 1'b0,
                           input t_out_item want = '0);
        t_dir_row row;
        row = '{it, typed, want};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // ------------------------------------------------------------------
    // Shadow CPU
    // ------------------------------------------------------------------
    function automatic logic branch_cond(logic [4:0] op, logic [1:0] cc);
        case (op)
            OP_B:    return 1'b1;
            OP_BEQ:  return cc == CMP_EQ;
            OP_BNE:  return cc == CMP_GT || cc == CMP_LT;
            OP_BLT:  return cc == CMP_LT;
            OP_BGT:  return cc == CMP_GT;
            default: return 1'b0;
        endcase
    endfunction

    // True when the instruction would put the machine into the stopped state
    function automatic bit ends_run(t_in_item it);
        logic [8:0] nxt;
        if (it.command == CMD_PRELOAD || cpu_stopped)
            return 1'b0;
        if ({1'b0, cpu_pc} >= cpu_plen || it.opcode >= OP_HALT)
            return 1'b1;
        nxt = branch_cond(it.opcode, cpu_cmp) ? {1'b0, it.address} : {1'b0, cpu_pc} + 9'd1;
        return nxt >= cpu_plen;
    endfunction

    // Applies one item to the shadow state and returns the result it must give
    task automatic cpu_execute(input t_in_item it, output t_out_item res);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] wv;
        logic [8:0] nxt;
        logic       tk;
        wv = '0;
        tk = 1'b0;
        if (it.command == CMD_PRELOAD) begin
            // preload works even on a stopped machine
            dmem[it.address] = it.load_value;
            wv = it.load_value;
        end else if (!cpu_stopped) begin
            if ({1'b0, cpu_pc} >= cpu_plen) begin
                // length lowered under the pc: nothing runs
                cpu_stopped = 1'b1;
                cpu_cause   = CAUSE_END;
            end else if (it.opcode >= OP_HALT) begin
                cpu_stopped = 1'b1;
                cpu_cause   = (it.opcode == OP_HALT) ? CAUSE_HALT : CAUSE_UNKNOWN;
            end else begin
                a = cpu_regs[it.src_reg];
                b = it.use_immediate ? it.immediate : cpu_regs[it.second_reg];
                x = cpu_regs[it.dest_reg];
                y = it.use_immediate ? it.immediate : a;
                case (it.opcode)
                    OP_LDR:  wv = dmem[it.address];
                    OP_STR: begin
                        wv = x;
                        dmem[it.address] = x;
                    end
                    OP_ADD:  wv = a + b;
                    OP_SUB:  wv = a - b;
                    OP_MOV:  wv = y;
                    OP_CMP:  cpu_cmp = (x == y) ? CMP_EQ : ((x > y) ? CMP_GT : CMP_LT);
                    OP_AND:  wv = a & b;
                    OP_ORR:  wv = a | b;
                    OP_EOR:  wv = a ^ b;
                    OP_MVN:  wv = ~a;
                    OP_LSL:  wv = (b >= 8) ? 8'd0 : a << b;
                    OP_LSR:  wv = (b >= 8) ? 8'd0 : a >> b;
                    default: ;  // nop and branches
                endcase
                case (it.opcode)
                    OP_LDR, OP_ADD, OP_SUB, OP_MOV, OP_AND, OP_ORR, OP_EOR, OP_MVN,
                    OP_LSL, OP_LSR: cpu_regs[it.dest_reg] = wv;
                    default: ;
                endcase
                // a taken branch still reports taken when its target ends the program
                tk  = branch_cond(it.opcode, cpu_cmp);
                nxt = tk ? {1'b0, it.address} : {1'b0, cpu_pc} + 9'd1;
                if (nxt >= cpu_plen) begin
                    cpu_stopped = 1'b1;
                    cpu_cause   = CAUSE_END;
                end else begin
                    cpu_pc = nxt[7:0];
                end
            end
        end
        res = '{cpu_pc, cpu_stopped, cpu_cause, wv, cpu_cmp, tk};
    endtask

    // Random instruction that keeps the machine running: anything that would
    // stop it is turned into a jump back inside the program.
    function automatic t_in_item random_instr();
        t_in_item   it;
        logic [7:0] last_line;
        last_line = 8'(cpu_plen - 9'd1);
        it = mk_op(5'($urandom_range(0, OP_LSR)), $urandom_range(0, 7), $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(0, 1),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 255),
                   $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
        it.load_value = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 15) begin
            it.command = CMD_PRELOAD;
        end else begin
            if (it.opcode >= OP_B && it.opcode <= OP_BGT && $urandom_range(0, 3) != 0)
                it.address = 8'($urandom_range(0, last_line));
            // give CMP a fair share of equal operands
            if (it.opcode == OP_CMP && it.use_immediate && $urandom_range(0, 2) == 0)
                it.immediate = cpu_regs[it.dest_reg];
            if (ends_run(it)) begin
                it.opcode  = OP_B;
                it.address = 8'($urandom_range(0, last_line));
            end
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // Predicts the item, queues its result, then offers it until the transfer.
    // A typed row queues its hand-written result in place of the prediction.
    // An idle cycle is put in before an item at random, keeping the idle share near IDLE_PCT.
    task automatic issue(input t_in_item it, input bit typed = 1'b0,
                         input t_out_item want = '0);
        t_out_item pred;
        cpu_execute(it, pred);
        pending_results.insert(pending_results.size(), typed ? want : pred);
        if (!steady && $urandom_range(0, 99 - IDLE_PCT) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    // Program length changes only with the core drained
    task automatic write_length(input int len);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= PLEN_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cpu_plen  = PLEN_W'(len);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, one long hold-off so the input side backs up
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_used && sent_count >= HOLD_AFTER) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (steady) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking, in order against the oldest pending result
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", out_item));
            end else begin
                want = pending_results.pop_front();
                if (out_item.next_pc !== want.next_pc)
                    report_mismatch($sformatf("next_pc %h, expected %h",
                                              out_item.next_pc, want.next_pc));
                if (out_item.stopped !== want.stopped)
                    report_mismatch($sformatf("stopped %b, expected %b",
                                              out_item.stopped, want.stopped));
                if (out_item.stop_cause !== want.stop_cause)
                    report_mismatch($sformatf("stop_cause %0d, expected %0d",
                                              out_item.stop_cause, want.stop_cause));
                if (out_item.written_value !== want.written_value)
                    report_mismatch($sformatf("written_value %h, expected %h",
                                              out_item.written_value, want.written_value));
                if (out_item.compare_code !== want.compare_code)
                    report_mismatch($sformatf("compare_code %0d, expected %0d",
                                              out_item.compare_code, want.compare_code));
                if (out_item.branch_taken !== want.branch_taken)
                    report_mismatch($sformatf("branch_taken %b, expected %b",
                                              out_item.branch_taken, want.branch_taken));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in_item     it;
        t_finish_kind ending;
        int unsigned  tgt;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;

        // shadow state after reset
        foreach (cpu_regs[i]) cpu_regs[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        cpu_cmp     = CMP_NONE;
        cpu_cause   = CAUSE_RUN;
        cpu_pc      = '0;
        cpu_stopped = 1'b0;
        cpu_plen    = PLEN_RESET;

        // Directed table, run with the reset program length.
        // op, dest, src, second, use_imm, imm, address
        add_row(mk_op(OP_NOP, 0, 0, 0, 0, 0, 0), 1'b1, running_at(1, 0, CMP_NONE, 0));
        add_row(mk_load(8'hFF, 8'hFF), 1'b1, running_at(1, 8'hFF, CMP_NONE, 0));
        add_row(mk_load(8'h80, 8'h81));
        add_row(mk_op(OP_LDR, 7, 0, 0, 0, 0, 8'hFF), 1'b1, running_at(2, 8'hFF, CMP_NONE, 0));
        // word never written reads as cleared
        add_row(mk_op(OP_LDR, 0, 0, 0, 0, 0, 17), 1'b1, running_at(3, 0, CMP_NONE, 0));
        // 8-bit wrap both ways
        add_row(mk_op(OP_ADD, 1, 7, 0, 1, 1, 0), 1'b1, running_at(4, 0, CMP_NONE, 0));
        add_row(mk_op(OP_SUB, 2, 1, 0, 1, 1, 0), 1'b1, running_at(5, 8'hFF, CMP_NONE, 0));
        add_row(mk_op(OP_MOV, 3, 0, 0, 1, 8'h5A, 0));
        add_row(mk_op(OP_MOV, 4, 3, 0, 0, 0, 0));
        add_row(mk_op(OP_ADD, 5, 3, 4, 0, 0, 0));
        add_row(mk_op(OP_AND, 6, 7, 3, 0, 0, 0));
        add_row(mk_op(OP_ORR, 6, 3, 0, 1, 8'hA5, 0));
        add_row(mk_op(OP_EOR, 6, 7, 3, 0, 0, 0));
        // MVN reads its register source, immediate ignored
        add_row(mk_op(OP_MVN, 1, 3, 7, 1, 8'hFF, 0));
        add_row(mk_op(OP_LSL, 1, 7, 0, 1, 7, 0));
        // shift counts of 8 and up clear the result
        add_row(mk_op(OP_LSL, 1, 7, 0, 1, 8, 0), 1'b1, running_at(14, 0, CMP_NONE, 0));
        add_row(mk_op(OP_LSR, 1, 7, 0, 1, 8'hFF, 0), 1'b1, running_at(15, 0, CMP_NONE, 0));
        add_row(mk_op(OP_STR, 7, 0, 0, 0, 0, 200), 1'b1, running_at(16, 8'hFF, CMP_NONE, 0));
        add_row(mk_op(OP_CMP, 7, 0, 0, 1, 8'hFF, 0), 1'b1, running_at(17, 0, CMP_EQ, 0));
        add_row(mk_op(OP_BEQ, 0, 0, 0, 0, 0, 40), 1'b1, running_at(40, 0, CMP_EQ, 1));
        add_row(mk_op(OP_CMP, 0, 7, 0, 0, 0, 0));
        add_row(mk_op(OP_BGT, 0, 0, 0, 0, 0, 100));
        // branch to line 0
        add_row(mk_op(OP_BLT, 0, 0, 0, 0, 0, 0), 1'b1, running_at(0, 0, CMP_LT, 1));
        add_row(mk_op(OP_CMP, 7, 0, 0, 1, 0, 0));
        add_row(mk_op(OP_BNE, 0, 0, 0, 0, 0, 77));
        add_row(mk_op(OP_LDR, 2, 0, 0, 0, 0, 200));
        add_row(mk_op(OP_B, 0, 0, 0, 0, 0, 3));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            issue(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        // Random programs under several program lengths. Parking the pc on
        // line 0 first keeps a shorter length from cutting the program off.
        foreach (plan_len[ph]) begin
            issue(mk_op(OP_B, 0, 0, 0, 0, 0, 0));
            write_length((plan_len[ph] == 0) ? $urandom_range(2, 256) : plan_len[ph]);
            steady = (ph == 3);
            repeat (plan_items[ph]) issue(random_instr());
            steady = 1'b0;
        end

        // Stop the machine, one way chosen per run
        ending = t_finish_kind'($urandom_range(FIN_HALT, FIN_FETCH_PAST));
        issue(mk_op(OP_B, 0, 0, 0, 0, 0, 0));
        if (ending == FIN_FETCH_PAST) begin
            // move the pc up, then drop the length to the pc or below it
            write_length(PLEN_RESET);
            tgt = $urandom_range(1, 255);
            issue(mk_op(OP_B, 0, 0, 0, 0, 0, tgt));
            write_length($urandom_range(1, tgt));
            issue(mk_op(5'($urandom_range(0, 31)), $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255),
                        $urandom_range(0, 255)));
        end else begin
            write_length($urandom_range(1, 255));
            case (ending)
                FIN_HALT:
                    issue(mk_op(OP_HALT, $urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 1),
                                $urandom_range(0, 255), $urandom_range(0, 255)));
                FIN_UNKNOWN:
                    issue(mk_op(5'($urandom_range(OP_HALT + 1, 31)), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 1), $urandom_range(0, 255),
                                $urandom_range(0, 255)));
                FIN_LAST_LINE: begin
                    // the ADD still lands, then the program runs out
                    issue(mk_op(OP_B, 0, 0, 0, 0, 0, 8'(cpu_plen - 9'd1)));
                    issue(mk_op(OP_ADD, $urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 1),
                                $urandom_range(0, 255), 0));
                end
                default:
                    issue(mk_op(OP_B, 0, 0, 0, 0, 0, $urandom_range(cpu_plen, 255)));
            endcase
        end

        // Stopped: execute items change nothing, preloads still write
        repeat (STOPPED_ITEMS) begin
            it = mk_op(5'($urandom_range(0, 31)), $urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                it.command    = CMD_PRELOAD;
                it.load_value = 8'($urandom_range(0, 255));
            end
            issue(it);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_eight_register_cpu_execute_step_core passed");
        else
            $display("tb_eight_register_cpu_execute_step_core failed");
        $finish;
    end

endmodule
